/* sv/avr_pkg.sv */
// shared types, constants and tables of the axis-angle rotation block
package avr_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int SQRT_STEPS      = 32;
   localparam int DIV_STEPS       = 31;
   localparam int CORDIC_STEPS    = 30;

   localparam logic signed [35:0] Q30_PI     = 36'sd3373259426;
   localparam logic signed [35:0] Q30_TWOPI  = 36'sd6746518852;
   localparam logic signed [35:0] Q30_HALFPI = 36'sd1686629713;
   localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE    = 34'sd1073741824;

   // classified item handed from the front to the back
   typedef struct packed {
      logic [2:0][31:0] vec;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             zero;
      logic [19:0]      angle;
   } entry_type;

   function automatic logic signed [35:0] atan_q30(input int idx);
      logic signed [35:0] val;
      unique case (idx)
         0:  val = 36'sd843314856;
         1:  val = 36'sd497837829;
         2:  val = 36'sd263043836;
         3:  val = 36'sd133525158;
         4:  val = 36'sd67021686;
         5:  val = 36'sd33543515;
         6:  val = 36'sd16775850;
         7:  val = 36'sd8388437;
         8:  val = 36'sd4194282;
         9:  val = 36'sd2097149;
         10: val = 36'sd1048575;
         11: val = 36'sd524287;
         12: val = 36'sd262143;
         13: val = 36'sd131071;
         14: val = 36'sd65535;
         15: val = 36'sd32767;
         16: val = 36'sd16383;
         17: val = 36'sd8191;
         18: val = 36'sd4095;
         19: val = 36'sd2047;
         20: val = 36'sd1023;
         21: val = 36'sd511;
         22: val = 36'sd255;
         23: val = 36'sd127;
         24: val = 36'sd63;
         25: val = 36'sd31;
         26: val = 36'sd15;
         27: val = 36'sd7;
         28: val = 36'sd3;
         29: val = 36'sd1;
         default: val = 36'sd0;
      endcase
      return val;
   endfunction

endpackage

/* sv/axis_angle_vector_rotate.sv */
// top level of the axis-angle vector rotation block
//
//  channel   direction  tdata                                     tuser
//  req_      in         vec_x/y/z, axis_x/y/z, angle              -
//  rsp_      out        rot_x/y/z                                 zero_axis, saturated
//
// one item a clock sustained while rsp_ is not stalled; the back pipeline runs through
// the 32-stage square root, the 31-stage divider and the product stages
// reset clears the queue pointers, the queue count and the pipeline valid bits only
// a stalled rsp_ freezes the whole back pipeline; the queue then takes up to
// QUEUE_DEPTH more items before req_tready drops
module axis_angle_vector_rotate #(
   parameter int QUEUE_DEPTH = avr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [215:0] req_tdata,  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // rot_x, rot_y, rot_z
   output logic [1:0]   rsp_tuser   // zero_axis, saturated
);
   import avr_pkg::*;

   entry_type   push_data, pop_data;
   logic        pop_valid, pop_ready;
   logic [31:0] rot_x, rot_y, rot_z;
   logic        zero_axis, saturated;

   avr_front u_front (
      .vec_x  (req_tdata[31:0]),
      .vec_y  (req_tdata[63:32]),
      .vec_z  (req_tdata[95:64]),
      .axis_x (req_tdata[127:96]),
      .axis_y (req_tdata[159:128]),
      .axis_z (req_tdata[191:160]),
      .angle  (req_tdata[211:192]),
      .entry  (push_data)
   );

   avr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   avr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rot_x     (rot_x),
      .rot_y     (rot_y),
      .rot_z     (rot_z),
      .zero_axis (zero_axis),
      .saturated (saturated)
   );

   assign rsp_tdata = {rot_z, rot_y, rot_x};
   assign rsp_tuser = {saturated, zero_axis};

endmodule

/* sv/avr_front.sv */
// front end: axis magnitudes, zero-axis check and power-of-two axis scaling
module avr_front (
   input  logic [31:0]        vec_x,
   input  logic [31:0]        vec_y,
   input  logic [31:0]        vec_z,
   input  logic [31:0]        axis_x,
   input  logic [31:0]        axis_y,
   input  logic [31:0]        axis_z,
   input  logic [19:0]        angle,
   output avr_pkg::entry_type entry
);
   import avr_pkg::*;

   logic [2:0][31:0] axis;
   logic [2:0][31:0] mag;
   logic [31:0]      mx;
   logic [4:0]       msb;
   logic [4:0]       shift;

   always_comb begin
      axis = {axis_z, axis_y, axis_x};
      for (int i = 0; i < 3; i++) begin
         mag[i] = axis[i][31] ? (~axis[i] + 32'd1) : axis[i];
      end
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      msb = '0;
      for (int b = 0; b < 32; b++) begin
         if (mx[b]) msb = 5'(b);
      end
      // bring the largest component up to at least 2^30
      shift = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
      for (int i = 0; i < 3; i++) begin
         entry.mag[i] = mag[i] << shift;
         entry.neg[i] = axis[i][31];
      end
      entry.vec   = {vec_z, vec_y, vec_x};
      entry.zero  = (mx == 32'd0);
      entry.angle = angle;
   end

endmodule

/* sv/avr_queue.sv */
// short item queue between front and back
module avr_queue #(
   parameter int DEPTH = avr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  avr_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output avr_pkg::entry_type pop_data
);
   import avr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push_ok, pop_ok;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_ok    = push_valid && push_ready;
   assign pop_ok     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push_ok, pop_ok})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* sv/avr_cordic.sv */
// pipelined angle reduction and rotation-mode cordic giving cos and sin in q.30
module avr_cordic (
   input  logic                clock,
   input  logic                en,
   input  logic [19:0]         angle,
   output logic signed [32:0]  cos_q,
   output logic signed [32:0]  sin_q
);
   import avr_pkg::*;

   logic signed [35:0] th1_ff, th2_ff, z0_ff;
   logic               neg3_ff;
   logic signed [35:0] th0;
   logic signed [33:0] x_ff [CORDIC_STEPS];
   logic signed [33:0] y_ff [CORDIC_STEPS];
   logic signed [35:0] z_ff [CORDIC_STEPS];
   logic               ng_ff [CORDIC_STEPS];
   logic signed [33:0] x_in [CORDIC_STEPS];
   logic signed [33:0] y_in [CORDIC_STEPS];
   logic signed [35:0] z_in [CORDIC_STEPS];
   logic signed [32:0] cos_ff, sin_ff;

   function automatic logic signed [35:0] wrap(input logic signed [35:0] th);
      logic signed [35:0] res;
      if (th > Q30_PI) res = th - Q30_TWOPI;
      else if (th < -Q30_PI) res = th + Q30_TWOPI;
      else res = th;
      return res;
   endfunction

   assign th0 = $signed({{2{angle[19]}}, angle, 14'b0});

   always_comb begin
      logic signed [33:0] xp, yp;
      logic signed [35:0] zp;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xp = (i == 0) ? CORDIC_K : x_ff[(i == 0) ? 0 : i - 1];
         yp = (i == 0) ? 34'sd0 : y_ff[(i == 0) ? 0 : i - 1];
         zp = (i == 0) ? z0_ff : z_ff[(i == 0) ? 0 : i - 1];
         if (zp >= 0) begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - atan_q30(i);
         end else begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + atan_q30(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         th1_ff <= wrap(th0);
         th2_ff <= wrap(th1_ff);
         // fold into the right half plane, negate at the end
         if (th2_ff > Q30_HALFPI) begin
            z0_ff   <= th2_ff - Q30_PI;
            neg3_ff <= 1'b1;
         end else if (th2_ff < -Q30_HALFPI) begin
            z0_ff   <= th2_ff + Q30_PI;
            neg3_ff <= 1'b1;
         end else begin
            z0_ff   <= th2_ff;
            neg3_ff <= 1'b0;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i]  <= x_in[i];
            y_ff[i]  <= y_in[i];
            z_ff[i]  <= z_in[i];
            ng_ff[i] <= (i == 0) ? neg3_ff : ng_ff[(i == 0) ? 0 : i - 1];
         end
         cos_ff <= 33'(ng_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1]);
         sin_ff <= 33'(ng_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1]);
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

/* sv/avr_back.sv */
// back end: normalising pipeline (square root, division), products and saturation
module avr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  avr_pkg::entry_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rot_x,
   output logic [31:0]        rot_y,
   output logic [31:0]        rot_z,
   output logic               zero_axis,
   output logic               saturated
);
   import avr_pkg::*;

   // one valid bit per pipeline stage from the queue to the result registers
   localparam int LAT = 75;

   logic en;
   logic vld_ff [LAT];

   logic [2:0][31:0] vd_ff   [71];
   logic [2:0]       sgd_ff  [67];
   logic             zd_ff   [74];
   logic [2:0][31:0] magd_ff [35];
   logic [19:0]      angd_ff [37];

   logic [63:0] sqr_ff [3];
   logic [63:0] l2_ff;

   logic [35:0] srem_ff [SQRT_STEPS];
   logic [31:0] sroot_ff [SQRT_STEPS];
   logic [63:0] sval_ff [SQRT_STEPS];
   logic [35:0] srem_in [SQRT_STEPS];
   logic [31:0] sroot_in [SQRT_STEPS];
   logic [63:0] sval_in [SQRT_STEPS];

   logic [61:0] num_ff [3];
   logic [31:0] dv36_ff;

   logic [2:0][32:0] drem_ff [DIV_STEPS];
   logic [2:0][30:0] dq_ff   [DIV_STEPS];
   logic [2:0][30:0] dlo_ff  [DIV_STEPS];
   logic [31:0]      ddv_ff  [DIV_STEPS];
   logic [2:0][32:0] drem_in [DIV_STEPS];
   logic [2:0][30:0] dq_in   [DIV_STEPS];
   logic [2:0][30:0] dlo_in  [DIV_STEPS];
   logic [31:0]      ddv_in  [DIV_STEPS];

   logic signed [31:0] n_ff [3], n69_ff [3], n70_ff [3];
   logic signed [63:0] pd_ff [3], pca_ff [3], pcb_ff [3];
   logic signed [35:0] dot_ff, cr_ff [3], cr71_ff [3];
   logic signed [67:0] pw_ff [3];
   logic signed [37:0] w_ff [3];
   logic signed [64:0] vc_ff [3], vc73_ff [3];
   logic signed [68:0] cs_ff [3], cs73_ff [3];
   logic signed [33:0] omc_ff;
   logic signed [71:0] wo_ff [3];
   logic signed [73:0] acc_ff [3];

   logic signed [32:0] cos_q, sin_q;

   logic [31:0] rot_ff [3], rot_in [3];
   logic        zero_ff, sat_ff, zero_in, sat_in;

   function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign pop_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) vld_ff[j] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= pop_valid;
         for (int j = 1; j < LAT; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   // sideband delay lines
   always_ff @(posedge clock) begin
      if (en) begin
         vd_ff[0]   <= pop_data.vec;
         sgd_ff[0]  <= pop_data.neg;
         zd_ff[0]   <= pop_data.zero;
         magd_ff[0] <= pop_data.mag;
         angd_ff[0] <= pop_data.angle;
         for (int j = 1; j < 71; j++) vd_ff[j] <= vd_ff[j-1];
         for (int j = 1; j < 67; j++) sgd_ff[j] <= sgd_ff[j-1];
         for (int j = 1; j < 74; j++) zd_ff[j] <= zd_ff[j-1];
         for (int j = 1; j < 35; j++) magd_ff[j] <= magd_ff[j-1];
         for (int j = 1; j < 37; j++) angd_ff[j] <= angd_ff[j-1];
      end
   end

   // square root, two bits of the radicand a stage
   always_comb begin
      logic [35:0] prem;
      logic [31:0] proot;
      logic [63:0] pval;
      logic [35:0] rem2, trial;
      for (int t = 0; t < SQRT_STEPS; t++) begin
         prem  = (t == 0) ? 36'd0 : srem_ff[(t == 0) ? 0 : t - 1];
         proot = (t == 0) ? 32'd0 : sroot_ff[(t == 0) ? 0 : t - 1];
         pval  = (t == 0) ? l2_ff : sval_ff[(t == 0) ? 0 : t - 1];
         rem2  = {prem[33:0], pval[63:62]};
         trial = {2'b00, proot, 2'b01};
         if (rem2 >= trial) begin
            srem_in[t]  = rem2 - trial;
            sroot_in[t] = {proot[30:0], 1'b1};
         end else begin
            srem_in[t]  = rem2;
            sroot_in[t] = {proot[30:0], 1'b0};
         end
         sval_in[t] = {pval[61:0], 2'b00};
      end
   end

   // restoring division, one quotient bit a stage, three lanes
   always_comb begin
      logic [32:0] pr;
      logic [30:0] plo, pq;
      logic [31:0] pdv;
      logic [33:0] r2;
      for (int t = 0; t < DIV_STEPS; t++) begin
         pdv = (t == 0) ? dv36_ff : ddv_ff[(t == 0) ? 0 : t - 1];
         ddv_in[t] = pdv;
         for (int i = 0; i < 3; i++) begin
            pr  = (t == 0) ? {2'b00, num_ff[i][61:31]} : drem_ff[(t == 0) ? 0 : t - 1][i];
            plo = (t == 0) ? num_ff[i][30:0] : dlo_ff[(t == 0) ? 0 : t - 1][i];
            pq  = (t == 0) ? 31'd0 : dq_ff[(t == 0) ? 0 : t - 1][i];
            r2  = {pr, plo[30]};
            if (r2 >= {2'b00, pdv}) begin
               drem_in[t][i] = 33'(r2 - {2'b00, pdv});
               dq_in[t][i]   = {pq[29:0], 1'b1};
            end else begin
               drem_in[t][i] = r2[32:0];
               dq_in[t][i]   = {pq[29:0], 1'b0};
            end
            dlo_in[t][i] = {plo[29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sqr_ff[i] <= 64'(magd_ff[0][i]) * 64'(magd_ff[0][i]);
         end
         l2_ff <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
         for (int t = 0; t < SQRT_STEPS; t++) begin
            srem_ff[t]  <= srem_in[t];
            sroot_ff[t] <= sroot_in[t];
            sval_ff[t]  <= sval_in[t];
         end
         // rounded quotient: add half the divisor to the numerator
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {magd_ff[34][i], 30'b0}
                       + {31'b0, sroot_ff[SQRT_STEPS-1][31:1]};
         end
         dv36_ff <= sroot_ff[SQRT_STEPS-1];
         for (int t = 0; t < DIV_STEPS; t++) begin
            drem_ff[t] <= drem_in[t];
            dq_ff[t]   <= dq_in[t];
            dlo_ff[t]  <= dlo_in[t];
            ddv_ff[t]  <= ddv_in[t];
         end
      end
   end

   avr_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .angle (angd_ff[36]),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   // products, dot and cross, final combination
   always_ff @(posedge clock) begin
      logic signed [65:0] sd;
      logic signed [64:0] dc;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= sgd_ff[66][i] ? -$signed({1'b0, dq_ff[DIV_STEPS-1][i]})
                                     :  $signed({1'b0, dq_ff[DIV_STEPS-1][i]});
            pd_ff[i] <= mul32(n_ff[i], $signed(vd_ff[67][i]));
         end
         pca_ff[0] <= mul32(n_ff[1], $signed(vd_ff[67][2]));
         pcb_ff[0] <= mul32(n_ff[2], $signed(vd_ff[67][1]));
         pca_ff[1] <= mul32(n_ff[2], $signed(vd_ff[67][0]));
         pcb_ff[1] <= mul32(n_ff[0], $signed(vd_ff[67][2]));
         pca_ff[2] <= mul32(n_ff[0], $signed(vd_ff[67][1]));
         pcb_ff[2] <= mul32(n_ff[1], $signed(vd_ff[67][0]));
         n69_ff <= n_ff;
         n70_ff <= n69_ff;

         sd = 66'(pd_ff[0]) + 66'(pd_ff[1]) + 66'(pd_ff[2]);
         dot_ff <= 36'((sd + 66'sd536870912) >>> 30);
         for (int i = 0; i < 3; i++) begin
            dc = 65'(pca_ff[i]) - 65'(pcb_ff[i]);
            cr_ff[i] <= 36'((dc + 65'sd536870912) >>> 30);
         end

         for (int i = 0; i < 3; i++) begin
            pw_ff[i]   <= 68'(n70_ff[i]) * 68'(dot_ff);
            cr71_ff[i] <= cr_ff[i];
            w_ff[i]    <= 38'((pw_ff[i] + 68'sd536870912) >>> 30);
            vc_ff[i]   <= 65'($signed(vd_ff[70][i])) * 65'(cos_q);
            cs_ff[i]   <= 69'(cr71_ff[i]) * 69'(sin_q);
            wo_ff[i]   <= 72'(w_ff[i]) * 72'(omc_ff);
            vc73_ff[i] <= vc_ff[i] >>> 2;
            cs73_ff[i] <= cs_ff[i] >>> 2;
            acc_ff[i]  <= 74'(vc73_ff[i]) + 74'(cs73_ff[i]) + 74'(wo_ff[i] >>> 2);
         end
         omc_ff <= Q30_ONE - 34'(cos_q);
      end
   end

   // rounding, saturation and zero-axis override
   always_comb begin
      logic signed [73:0] r;
      sat_in  = 1'b0;
      zero_in = zd_ff[73];
      for (int i = 0; i < 3; i++) begin
         r = (acc_ff[i] + 74'sd134217728) >>> 28;
         if (r > 74'sd2147483647) begin
            rot_in[i] = 32'h7fff_ffff;
            sat_in    = 1'b1;
         end else if (r < -74'sd2147483648) begin
            rot_in[i] = 32'h8000_0000;
            sat_in    = 1'b1;
         end else begin
            rot_in[i] = r[31:0];
         end
         if (zero_in) rot_in[i] = 32'd0;
      end
      if (zero_in) sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff  <= rot_in;
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
      end
   end

   assign rot_x     = rot_ff[0];
   assign rot_y     = rot_ff[1];
   assign rot_z     = rot_ff[2];
   assign zero_axis = zero_ff;
   assign saturated = sat_ff;

endmodule

/* verif/axis_angle_vector_rotate_test.sv */
// testbench of the axis-angle vector rotation block: directed table, then random items
`timescale 1ns / 1ps

module axis_angle_vector_rotate_test;

   typedef struct packed {
      logic signed [31:0] vx, vy, vz;
      logic signed [31:0] ax, ay, az;
      logic signed [19:0] ang;
   } rot_req_type;

   typedef struct packed {
      logic signed [31:0] rx, ry, rz;
      logic               zero_axis;
      logic               sat;
   } rot_rsp_type;

   typedef struct {
      rot_req_type req;
      bit          typed;
      rot_rsp_type want;
   } stim_row_type;

   localparam longint Q30_ONE    = 64'sd1073741824;
   localparam longint Q30_PI     = 64'sd3373259426;
   localparam longint Q30_TWOPI  = 64'sd6746518852;
   localparam longint Q30_HALFPI = 64'sd1686629713;
   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam longint CYCLE_LIMIT = 64'd600000;
   localparam int     RANDOM_ITEMS = 1530;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [215:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   rot_rsp_type  expected_rotations[$];
   stim_row_type table_rows[$];
   int           failures = 0;
   int           results_seen = 0;
   int           sat_seen = 0;
   int           zero_seen = 0;
   int           rsp_wait = 0;
   longint       cycle_count = 0;

   axis_angle_vector_rotate DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint atan_step(int i);
      longint tbl[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149,
                          1048575, 524287, 262143, 131071, 65535,
                          32767, 16383, 8191, 4095, 2047,
                          1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};
      return tbl[i];
   endfunction

   function automatic rot_rsp_type rotate_vector(rot_req_type r);
      rot_rsp_type o;
      longint v[3], a[3], n[3], cr[3];
      longint unsigned mag[3], mx, l2, sq;
      longint th, x, y, z, dx, dy, c, s, omc, dot, w, acc, res;
      bit neg;
      int k;
      o = '0;
      v = '{longint'(r.vx), longint'(r.vy), longint'(r.vz)};
      a = '{longint'(r.ax), longint'(r.ay), longint'(r.az)};
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = a[i] < 0 ? -a[i] : a[i];
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
         o.zero_axis = 1'b1;
         return o;
      end
      k = 0;
      while ((mx << k) < (64'd1 << 30)) k++;
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] <<= k;
         l2 += mag[i] * mag[i];
      end
      sq = int_sqrt(l2);
      for (int i = 0; i < 3; i++) begin
         longint unsigned q;
         q = ((mag[i] << 30) + (sq >> 1)) / sq;
         n[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
      // angle reduction into the cordic range
      th = longint'(r.ang) * 16384;
      for (int p = 0; p < 2; p++) begin
         if (th > Q30_PI) th -= Q30_TWOPI;
         else if (th < -Q30_PI) th += Q30_TWOPI;
      end
      neg = 0;
      if (th > Q30_HALFPI) begin
         th -= Q30_PI; neg = 1;
      end else if (th < -Q30_HALFPI) begin
         th += Q30_PI; neg = 1;
      end
      x = CORDIC_GAIN; y = 0; z = th;
      for (int p = 0; p < 30; p++) begin
         dx = y >>> p; dy = x >>> p;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(p);
         end else begin
            x += dx; y -= dy; z += atan_step(p);
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
      omc = Q30_ONE - c;
      dot = round_shift(n[0] * v[0] + n[1] * v[1] + n[2] * v[2], 30);
      cr[0] = round_shift(n[1] * v[2] - n[2] * v[1], 30);
      cr[1] = round_shift(n[2] * v[0] - n[0] * v[2], 30);
      cr[2] = round_shift(n[0] * v[1] - n[1] * v[0], 30);
      for (int i = 0; i < 3; i++) begin
         w = round_shift(n[i] * dot, 30);
         acc = ((v[i] * c) >>> 2) + ((cr[i] * s) >>> 2) + ((w * omc) >>> 2);
         res = round_shift(acc, 28);
         if (res > 64'sd2147483647) begin
            res = 64'sd2147483647; o.sat = 1'b1;
         end else if (res < -64'sd2147483648) begin
            res = -64'sd2147483648; o.sat = 1'b1;
         end
         if (i == 0) o.rx = res[31:0];
         else if (i == 1) o.ry = res[31:0];
         else o.rz = res[31:0];
      end
      return o;
   endfunction

   function automatic logic [215:0] pack_req(rot_req_type r);
      return {4'b0, r.ang, r.az, r.ay, r.ax, r.vz, r.vy, r.vx};
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 16'hffff)) - 32768);
         3: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
         default: return 32'($signed($urandom_range(0, 32'hfffff)) - 32'sh80000);
      endcase
   endfunction

   function automatic rot_req_type rand_item();
      rot_req_type r;
      r.vx = rand_coord(); r.vy = rand_coord(); r.vz = rand_coord();
      r.ax = rand_coord(); r.ay = rand_coord(); r.az = rand_coord();
      case ($urandom_range(0, 9))
         0: begin
            r.ax = 0; r.ay = 0; r.az = 0;
         end
         1: begin
            r.ay = 0; r.az = 0;
         end
         2: r.az = 0;
         default: ;
      endcase
      r.ang = $urandom_range(0, 3) == 0 ? 20'($urandom)
                                          : 20'($signed($urandom_range(0, 823550)) - 411775);
      return r;
   endfunction

   task automatic add_row(rot_req_type r, bit typed, rot_rsp_type want);
      stim_row_type row;
      row.req = r; row.typed = typed; row.want = want;
      table_rows.push_back(row);
   endtask

   // valid stays high between items sent back to back
   task automatic send_item(rot_req_type r, bit typed, rot_rsp_type want);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_req(r);
      do @(posedge clock); while (!req_tready);
      expected_rotations.push_back(typed ? want : rotate_vector(r));
   endtask

   // result side: random stall per item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rot_rsp_type got, want;
            int gap;
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0],
                   rsp_tuser[1]};
            results_seen++;
            if (got.sat) sat_seen++;
            if (got.zero_axis) zero_seen++;
            if (expected_rotations.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, got);
               failures++;
            end else begin
               want = expected_rotations.pop_front();
               if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz)
                  begin
                  $display("%0t: rot mismatch expected %h %h %h actual %h %h %h", $time,
                           want.rx, want.ry, want.rz, got.rx, got.ry, got.rz);
                  failures++;
               end
               if (got.zero_axis !== want.zero_axis || got.sat !== want.sat) begin
                  $display("%0t: flag mismatch expected zero %b sat %b actual %b %b",
                           $time, want.zero_axis, want.sat, got.zero_axis, got.sat);
                  failures++;
               end
            end
            gap = $urandom_range(0, 9);
            rsp_wait   <= gap;
            rsp_tready <= (gap == 0);
         end else if (rsp_wait > 1) begin
            rsp_wait   <= rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_wait   <= 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      rot_req_type r;
      rot_rsp_type z;
      z = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero axis gives zeros and the flag
      r = '{32'h7fffffff, 32'h80000000, 32'h12345678, 0, 0, 0, 20'h12345};
      add_row(r, 1, '{0, 0, 0, 1'b1, 1'b0});
      // zero vector rotates to zero
      r = '{0, 0, 0, 32'h00010000, 0, 0, 20'h1921f};
      add_row(r, 1, z);
      // zero angle about x leaves a small vector alone
      r = '{32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00010000, 0, 0, 0};
      add_row(r, 0, z);
      // quarter turns, half turns, both signs and beyond two pi
      r = '{32'h00010000, 0, 0, 0, 0, 32'h00010000, 20'h1921f};
      add_row(r, 0, z);
      r = '{32'h00010000, 0, 0, 0, 0, 32'hffff0000, 20'hbe6e1};
      add_row(r, 0, z);
      r = '{32'h00010000, 32'h00010000, 0, 0, 0, 32'h00000001, 20'h3243f};
      add_row(r, 0, z);
      r = '{32'h00030000, 32'h00010000, 32'h00020000, 1, 1, 1, 20'h7ffff};
      add_row(r, 0, z);
      r = '{32'h00030000, 32'h00010000, 32'h00020000, 1, 1, 1, 20'h80000};
      add_row(r, 0, z);
      r = '{32'h00030000, 32'h00010000, 32'h00020000, 32'h7fffffff, 32'h80000000,
            32'h7fffffff, 20'h6487f};
      add_row(r, 0, z);
      r = '{32'h00030000, 32'hfff10000, 32'h00020000, 32'h80000000, 0, 0, 20'h9b781};
      add_row(r, 0, z);
      // overflow in both directions
      r = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00010000, 32'hffff0000, 0,
            20'h0c90f};
      add_row(r, 0, z);
      r = '{32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 32'hffffffff, 20'h12d97};
      add_row(r, 0, z);
      r = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 20'h3243f};
      add_row(r, 0, z);
      r = '{32'hffffffff, 32'h00000001, 32'hffffffff, 0, 32'h00000001, 0, 20'h00001};
      add_row(r, 0, z);

      foreach (table_rows[i]) send_item(table_rows[i].req, table_rows[i].typed,
                                        table_rows[i].want);
      for (int i = 0; i < RANDOM_ITEMS; i++) send_item(rand_item(), 0, z);
      req_tvalid <= 1'b0;

      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d rotations: %0d with zero axis, %0d saturated",
               results_seen, zero_seen, sat_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/avr_pkg.sv
sv/avr_front.sv
sv/avr_queue.sv
sv/avr_cordic.sv
sv/avr_back.sv
sv/axis_angle_vector_rotate.sv
verif/axis_angle_vector_rotate_test.sv
